/* rtl/core/gto_pkg.sv */
// ----------------------------------------------------------------------------
// gto_pkg
// Types, constants and the arctangent table of the GPS track odometer.
// ----------------------------------------------------------------------------
package gto_pkg;

  // CORDIC iteration count (12 to 32)
  localparam int CORDIC_STEPS = 18;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 50;

  // Fixed-point scale factors
  localparam logic [32:0] RAD_Q62   = 33'd8048910508;  // radians per 1e-7 deg, Q62
  localparam logic [32:0] K_Q24     = 33'd186554154;   // mm per 1e-7 deg, Q24
  localparam logic [32:0] CORDIC_X0 = 33'd652032874;   // CORDIC gain, Q30
  localparam logic [32:0] ONE_Q30   = 33'd1073741824;
  localparam logic [30:0] DEG90     = 31'd900000000;
  localparam logic [30:0] DEG180    = 31'd1800000000;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_MANG, ST_MDY, ST_MP, ST_CORD, ST_MLO, ST_MHI, ST_DX, ST_NORM,
    ST_MA, ST_MB, ST_SQI, ST_SQRT, ST_ACC, ST_DIV, ST_SPD, ST_OUT
  } gto_state_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/gto_if.sv */
// ----------------------------------------------------------------------------
// gto_in_if / gto_out_if
// Valid/ready channels carrying track points and odometer results.
// ----------------------------------------------------------------------------
interface gto_in_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] latitude;
  logic signed [31:0] longitude;
  logic        [41:0] time_ms;
  logic               track_start;

  modport source (output valid, latitude, longitude, time_ms, track_start, input ready);
  modport sink   (input valid, latitude, longitude, time_ms, track_start, output ready);
endinterface

interface gto_out_if;
  logic               valid;
  logic               ready;
  logic        [39:0] total_distance_mm;
  logic        [31:0] speed_mm_per_s;
  logic               speed_valid;
  logic signed [42:0] elapsed_ms;
  logic signed [30:0] lat_min;
  logic signed [30:0] lat_max;
  logic signed [31:0] lon_min;
  logic signed [31:0] lon_max;
  logic        [41:0] time_min;
  logic        [41:0] time_max;

  modport source (output valid, total_distance_mm, speed_mm_per_s, speed_valid, elapsed_ms,
                  lat_min, lat_max, lon_min, lon_max, time_min, time_max, input ready);
  modport sink   (input valid, total_distance_mm, speed_mm_per_s, speed_valid, elapsed_ms,
                  lat_min, lat_max, lon_min, lon_max, time_min, time_max, output ready);
endinterface

/* rtl/core/gps_track_odometer_core.sv */
// ----------------------------------------------------------------------------
// gps_track_odometer_core
// Running track length, segment speed, elapsed time and bounding box of GPS
// points, built around one shared 33x33 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  ---------+-----------+-------------------------------------------------
//  in_ch    | sink      | point: latitude, longitude, time_ms, track_start
//  out_ch   | source    | totals, speed, elapsed time, bounding box
//
// The first point of a track goes straight to the output register. Other points
// run the angle and offset multiplies, the CORDIC, the normalise loop, the
// 32-step square root and, when the interval is positive, the bit-serial speed
// divide. rst_n is synchronous; in_ch.ready is high only when idle.
// A result waiting in the output register does not block the next request.
// ----------------------------------------------------------------------------
module gps_track_odometer_core (
  input  logic      clk,
  input  logic      rst_n,
  gto_in_if.sink    in_ch,
  gto_out_if.source out_ch
);

  gto_pkg::gto_state_t state_r, state_nxt;

  // control
  logic        have_point_r;
  logic        out_valid_r;
  logic [5:0]  cnt_r;
  logic        load_out;
  logic        first_pt;

  // per-point working registers
  logic [29:0] m_r;
  logic [31:0] dlat_r;
  logic [32:0] dlon_r;
  logic [41:0] dt_r;
  logic        dt_pos_r;
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p_r;
  logic signed [32:0] x_r, y_r, z_r;
  logic [59:0] p_r;
  logic [37:0] dy_r;
  logic [30:0] lo_r;
  logic [38:0] a_r, b_r;
  logic [3:0]  s_r;
  logic [61:0] sq_r;
  logic [62:0] rem_r, root_r;
  logic [49:0] num_r;
  logic [41:0] drem_r;
  logic [30:0] cos_c;

  // track state and result staging
  logic signed [30:0] prev_lat_r;
  logic signed [31:0] prev_lon_r;
  logic [41:0] prev_time_r, first_time_r;
  logic [39:0] sum_r;
  logic [31:0] spd_r;
  logic        spd_ok_r;
  logic signed [42:0] elapsed_r;
  logic signed [30:0] lat_min_r, lat_max_r;
  logic signed [31:0] lon_min_r, lon_max_r;
  logic [41:0] tmin_r, tmax_r;

  // output register
  logic [39:0] o_dist_r;
  logic [31:0] o_spd_r;
  logic        o_ok_r;
  logic signed [42:0] o_elapsed_r;
  logic signed [30:0] o_lat_min_r, o_lat_max_r;
  logic signed [31:0] o_lon_min_r, o_lon_max_r;
  logic [41:0] o_tmin_r, o_tmax_r;

  // input differences
  logic signed [31:0] dlat_s;
  logic signed [32:0] msum_s, dlon_s;
  logic [32:0] msum_abs;
  logic [30:0] m_half, m_clip, m_fold;
  logic [42:0] dt_full, el_full;

  always_comb begin
    dlat_s   = {in_ch.latitude[30], in_ch.latitude} - {prev_lat_r[30], prev_lat_r};
    msum_s   = {{2{in_ch.latitude[30]}}, in_ch.latitude} + {{2{prev_lat_r[30]}}, prev_lat_r};
    msum_abs = msum_s[32] ? 33'(-msum_s) : 33'(msum_s);
    m_half   = msum_abs[31:1];
    m_clip   = (m_half > gto_pkg::DEG180) ? gto_pkg::DEG180 : m_half;
    m_fold   = (m_clip > gto_pkg::DEG90) ? gto_pkg::DEG180 - m_clip : m_clip;
    dlon_s   = {in_ch.longitude[31], in_ch.longitude} - {prev_lon_r[31], prev_lon_r};
    dt_full  = {1'b0, in_ch.time_ms} - {1'b0, prev_time_r};
    el_full  = {1'b0, in_ch.time_ms} - {1'b0, first_time_r};
    first_pt = in_ch.track_start || !have_point_r;
  end

  // cosine clamped to [0, 1] in Q30
  always_comb begin
    if (x_r[32])
      cos_c = '0;
    else if (33'(x_r) > gto_pkg::ONE_Q30)
      cos_c = gto_pkg::ONE_Q30[30:0];
    else
      cos_c = x_r[30:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gto_pkg::ST_IDLE: if (in_ch.valid)
                          state_nxt = first_pt ? gto_pkg::ST_OUT : gto_pkg::ST_MANG;
      gto_pkg::ST_MANG: state_nxt = gto_pkg::ST_MDY;
      gto_pkg::ST_MDY:  state_nxt = gto_pkg::ST_MP;
      gto_pkg::ST_MP:   state_nxt = gto_pkg::ST_CORD;
      gto_pkg::ST_CORD: if (cnt_r == 6'(gto_pkg::CORDIC_STEPS - 1)) state_nxt = gto_pkg::ST_MLO;
      gto_pkg::ST_MLO:  state_nxt = gto_pkg::ST_MHI;
      gto_pkg::ST_MHI:  state_nxt = gto_pkg::ST_DX;
      gto_pkg::ST_DX:   state_nxt = gto_pkg::ST_NORM;
      gto_pkg::ST_NORM: if (a_r[38:31] == '0 && b_r[38:31] == '0) state_nxt = gto_pkg::ST_MA;
      gto_pkg::ST_MA:   state_nxt = gto_pkg::ST_MB;
      gto_pkg::ST_MB:   state_nxt = gto_pkg::ST_SQI;
      gto_pkg::ST_SQI:  state_nxt = gto_pkg::ST_SQRT;
      gto_pkg::ST_SQRT: if (cnt_r == 6'(gto_pkg::SQRT_STEPS - 1)) state_nxt = gto_pkg::ST_ACC;
      gto_pkg::ST_ACC:  state_nxt = dt_pos_r ? gto_pkg::ST_DIV : gto_pkg::ST_OUT;
      gto_pkg::ST_DIV:  if (cnt_r == 6'(gto_pkg::DIV_STEPS - 1)) state_nxt = gto_pkg::ST_SPD;
      gto_pkg::ST_SPD:  state_nxt = gto_pkg::ST_OUT;
      gto_pkg::ST_OUT:  if (!out_valid_r || out_ch.ready) state_nxt = gto_pkg::ST_IDLE;
      default:          state_nxt = gto_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshakes and multiplier operands
  always_comb begin
    in_ch.ready = (state_r == gto_pkg::ST_IDLE);
    load_out    = (state_r == gto_pkg::ST_OUT) && (!out_valid_r || out_ch.ready);
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      gto_pkg::ST_MANG: begin mul_a = {3'b0, m_r};          mul_b = gto_pkg::RAD_Q62; end
      gto_pkg::ST_MDY:  begin mul_a = {1'b0, dlat_r};       mul_b = gto_pkg::K_Q24;   end
      gto_pkg::ST_MP:   begin mul_a = dlon_r;               mul_b = gto_pkg::K_Q24;   end
      gto_pkg::ST_MLO:  begin mul_a = {1'b0, p_r[31:0]};    mul_b = {2'b0, cos_c};    end
      gto_pkg::ST_MHI:  begin mul_a = {5'b0, p_r[59:32]};   mul_b = {2'b0, cos_c};    end
      gto_pkg::ST_MA:   begin mul_a = {2'b0, a_r[30:0]};    mul_b = {2'b0, a_r[30:0]}; end
      gto_pkg::ST_MB:   begin mul_a = {2'b0, b_r[30:0]};    mul_b = {2'b0, b_r[30:0]}; end
      default:          begin mul_a = '0;                   mul_b = '0;               end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gto_pkg::ST_IDLE;
      have_point_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == gto_pkg::ST_IDLE && in_ch.valid)
        have_point_r <= 1'b1;
      if (load_out)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;
      if (state_r == gto_pkg::ST_CORD || state_r == gto_pkg::ST_SQRT ||
          state_r == gto_pkg::ST_DIV)
        cnt_r <= (state_nxt == state_r) ? cnt_r + 6'd1 : '0;
      else
        cnt_r <= '0;
    end
  end

  // datapath
  logic [61:0] dy_sum;
  logic [62:0] lo_sum;
  logic [60:0] dx_sum;
  logic [62:0] sq_bit, sq_try;
  logic [5:0]  sq_sh;
  logic [39:0] seg;
  logic [40:0] tot;
  logic [42:0] div_sh;
  logic [4:0]  ci;
  logic signed [32:0] xs, ys, at;

  always_comb begin
    dy_sum = mul_p_r[61:0] + 62'h800000;
    lo_sum = mul_p_r[62:0] + (63'd1 << 53);
    dx_sum = {1'b0, mul_p_r[59:0]} + {30'b0, lo_r};
    sq_sh  = 6'd62 - {cnt_r[4:0], 1'b0};
    sq_bit = 63'd1 << sq_sh;
    sq_try = root_r + sq_bit;
    seg    = {8'b0, root_r[31:0]} << s_r;
    tot    = {1'b0, sum_r} + {1'b0, seg};
    div_sh = {drem_r, num_r[49]};
    ci     = cnt_r[4:0];
    xs     = x_r >>> ci;
    ys     = y_r >>> ci;
    at     = {3'b0, gto_pkg::atan_q30(ci)};
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
    case (state_r)
      // take the point: differences, time checks, box and track state
      gto_pkg::ST_IDLE: if (in_ch.valid) begin
        dlat_r   <= dlat_s[31] ? 32'(-dlat_s) : 32'(dlat_s);
        dlon_r   <= dlon_s[32] ? 33'(-dlon_s) : 33'(dlon_s);
        m_r      <= m_fold[29:0];
        dt_r     <= dt_full[41:0];
        dt_pos_r <= !dt_full[42] && (dt_full != '0);
        spd_r    <= '0;
        spd_ok_r <= 1'b0;
        if (first_pt) begin
          sum_r        <= '0;
          first_time_r <= in_ch.time_ms;
          elapsed_r    <= '0;
          lat_min_r    <= in_ch.latitude;
          lat_max_r    <= in_ch.latitude;
          lon_min_r    <= in_ch.longitude;
          lon_max_r    <= in_ch.longitude;
          tmin_r       <= in_ch.time_ms;
          tmax_r       <= in_ch.time_ms;
        end else begin
          elapsed_r <= el_full;
          if (in_ch.latitude < lat_min_r)  lat_min_r <= in_ch.latitude;
          if (in_ch.latitude > lat_max_r)  lat_max_r <= in_ch.latitude;
          if (in_ch.longitude < lon_min_r) lon_min_r <= in_ch.longitude;
          if (in_ch.longitude > lon_max_r) lon_max_r <= in_ch.longitude;
          if (in_ch.time_ms < tmin_r)      tmin_r    <= in_ch.time_ms;
          if (in_ch.time_ms > tmax_r)      tmax_r    <= in_ch.time_ms;
        end
        prev_lat_r  <= in_ch.latitude;
        prev_lon_r  <= in_ch.longitude;
        prev_time_r <= in_ch.time_ms;
      end
      // angle ready: seed the CORDIC
      gto_pkg::ST_MDY: begin
        z_r <= {2'b0, mul_p_r[62:32]};
        x_r <= gto_pkg::CORDIC_X0;
        y_r <= '0;
      end
      gto_pkg::ST_MP: dy_r <= dy_sum[61:24];
      // rotation mode, one micro-rotation a cycle
      gto_pkg::ST_CORD: begin
        if (cnt_r == '0)
          p_r <= mul_p_r[59:0];
        if (!z_r[32]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end
      end
      gto_pkg::ST_MHI: lo_r <= lo_sum[62:32];
      gto_pkg::ST_DX: begin
        a_r <= dx_sum[60:22];
        b_r <= {1'b0, dy_r};
        s_r <= '0;
      end
      // bring both offsets under 2^31
      gto_pkg::ST_NORM: if (a_r[38:31] != '0 || b_r[38:31] != '0) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        s_r <= s_r + 4'd1;
      end
      gto_pkg::ST_MB: sq_r <= mul_p_r[61:0];
      gto_pkg::ST_SQI: begin
        rem_r  <= {1'b0, sq_r} + {1'b0, mul_p_r[61:0]};
        root_r <= '0;
      end
      // digit-by-digit square root
      gto_pkg::ST_SQRT: begin
        if (rem_r >= sq_try) begin
          rem_r  <= rem_r - sq_try;
          root_r <= (root_r >> 1) + sq_bit;
        end else begin
          root_r <= root_r >> 1;
        end
      end
      // accumulate and set up seg * 1000 / dt
      gto_pkg::ST_ACC: begin
        sum_r  <= tot[40] ? '1 : tot[39:0];
        num_r  <= ({10'b0, seg} << 10) - ({10'b0, seg} << 4) - ({10'b0, seg} << 3);
        drem_r <= '0;
      end
      // restoring divide, one quotient bit a cycle
      gto_pkg::ST_DIV: begin
        if (div_sh >= {1'b0, dt_r}) begin
          drem_r <= 42'(div_sh - {1'b0, dt_r});
          num_r  <= {num_r[48:0], 1'b1};
        end else begin
          drem_r <= div_sh[41:0];
          num_r  <= {num_r[48:0], 1'b0};
        end
      end
      gto_pkg::ST_SPD: begin
        spd_r    <= (num_r[49:32] != '0) ? '1 : num_r[31:0];
        spd_ok_r <= 1'b1;
      end
      default: ;
    endcase

    // output register
    if (load_out) begin
      o_dist_r    <= sum_r;
      o_spd_r     <= spd_r;
      o_ok_r      <= spd_ok_r;
      o_elapsed_r <= elapsed_r;
      o_lat_min_r <= lat_min_r;
      o_lat_max_r <= lat_max_r;
      o_lon_min_r <= lon_min_r;
      o_lon_max_r <= lon_max_r;
      o_tmin_r    <= tmin_r;
      o_tmax_r    <= tmax_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.total_distance_mm = o_dist_r;
  assign out_ch.speed_mm_per_s    = o_spd_r;
  assign out_ch.speed_valid       = o_ok_r;
  assign out_ch.elapsed_ms        = o_elapsed_r;
  assign out_ch.lat_min           = o_lat_min_r;
  assign out_ch.lat_max           = o_lat_max_r;
  assign out_ch.lon_min           = o_lon_min_r;
  assign out_ch.lon_max           = o_lon_max_r;
  assign out_ch.time_min          = o_tmin_r;
  assign out_ch.time_max          = o_tmax_r;

`ifndef NO_ASSERTIONS
  // a flagged-invalid speed is always reported as zero
  a_spd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.speed_valid |-> out_ch.speed_mm_per_s == '0)
    else $error("speed not zero while invalid");

  // the box stays ordered once seeded
  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.lat_min <= out_ch.lat_max && out_ch.lon_min <= out_ch.lon_max &&
                     out_ch.time_min <= out_ch.time_max)
    else $error("bounding box out of order");

  // a request is only taken while the sequencer idles, and work starts next cycle
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == gto_pkg::ST_OUT || state_r == gto_pkg::ST_MANG)
    else $error("sequencer did not start on request");
`endif

endmodule

/* tb/sv/gto_odometer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gto_odometer_checker
// Watches both channels of the track odometer. Every accepted request is run
// through a local fixed-point odometer model; each result leaving the block
// is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module gto_odometer_checker (
  input  logic clk,
  input  logic rst_n,
  gto_in_if    in_ch,
  gto_out_if   out_ch,
  output int   fail_count,
  output int   outstanding
);

  typedef struct packed {
    logic        [39:0] total_mm;
    logic        [31:0] speed;
    logic               spd_ok;
    logic        [42:0] elapsed;
    logic        [30:0] lat_lo;
    logic        [30:0] lat_hi;
    logic        [31:0] lon_lo;
    logic        [31:0] lon_hi;
    logic        [41:0] t_lo;
    logic        [41:0] t_hi;
  } odo_result_t;

  localparam longint unsigned K_MM  = 64'd186554154;
  localparam longint unsigned RAD62 = 64'd8048910508;
  localparam longint unsigned QUART = 64'd900000000;
  localparam longint unsigned HALF  = 64'd1800000000;
  localparam longint unsigned DMAX  = 64'hFF_FFFF_FFFF;
  localparam longint unsigned SMAX  = 64'hFFFF_FFFF;

  // floor(atan(2^-i) * 2^30)
  longint arctan_tab [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 7, 3, 1, 0, 0};

  // Track state of the local odometer
  longint          last_lat, last_lon;
  longint          bb_lat_lo, bb_lat_hi, bb_lon_lo, bb_lon_hi;
  logic   [41:0]   last_t, start_t, bb_t_lo, bb_t_hi;
  longint unsigned dist_acc;
  logic            seen_point;

  odo_result_t expected_results [$];

  assign outstanding = expected_results.size();

  // |cos| of a mean latitude, Q30, by CORDIC rotation
  function automatic longint cos_of_lat(longint unsigned m);
    longint x, y, z, xs, ys;
    int n;
    x = 652032874;
    y = 0;
    n = (gto_pkg::CORDIC_STEPS > 32) ? 32 : gto_pkg::CORDIC_STEPS;
    if (m > HALF) m = HALF;
    if (m > QUART) m = HALF - m;
    z = longint'((m * RAD62) >> 32);
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - arctan_tab[i];
      end else begin
        x = x + ys; y = y - xs; z = z + arctan_tab[i];
      end
    end
    if (x < 0) x = 0;
    if (x > 64'sd1073741824) x = 1073741824;
    return x;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Equirectangular segment length in mm from the last point
  function automatic longint unsigned segment_len(longint lat, longint lon);
    longint unsigned dlat, dlon, msum, c, dy, dx, p, mx, a, b;
    logic [127:0] wide;
    int s;
    dlat = (lat >= last_lat) ? lat - last_lat : last_lat - lat;
    dlon = (lon >= last_lon) ? lon - last_lon : last_lon - lon;
    msum = ((lat + last_lat) >= 0 ? lat + last_lat : -(lat + last_lat)) / 2;
    c    = longint'(cos_of_lat(msum));
    dy   = (dlat * K_MM + (64'd1 << 23)) >> 24;
    p    = dlon * K_MM;
    wide = 128'(p) * 128'(c) + (128'd1 << 53);
    dx   = 64'(wide >> 54);
    mx   = (dx > dy) ? dx : dy;
    s    = 0;
    while ((mx >> s) >= (64'd1 << 31)) s++;
    a = dx >> s;
    b = dy >> s;
    return floor_root(a * a + b * b) << s;
  endfunction

  function automatic odo_result_t predict_point(logic signed [30:0] lat_i,
                                                logic signed [31:0] lon_i,
                                                logic [41:0] t, logic first_flag);
    odo_result_t r;
    longint lat, lon, dt;
    longint unsigned seg, spd;
    lat = lat_i;
    lon = lon_i;
    r = '0;
    if (first_flag || !seen_point) begin
      dist_acc  = 0;
      start_t   = t;
      bb_lat_lo = lat; bb_lat_hi = lat;
      bb_lon_lo = lon; bb_lon_hi = lon;
      bb_t_lo   = t;   bb_t_hi   = t;
      seen_point = 1'b1;
    end else begin
      seg = segment_len(lat, lon);
      dt  = longint'({22'd0, t}) - longint'({22'd0, last_t});
      dist_acc = dist_acc + seg;
      if (dist_acc > DMAX) dist_acc = DMAX;
      if (dt > 0) begin
        spd = seg * 1000 / longint'(dt);
        if (spd > SMAX) spd = SMAX;
        r.speed  = spd[31:0];
        r.spd_ok = 1'b1;
      end
      r.elapsed = 43'({1'b0, t} - {1'b0, start_t});
      if (lat < bb_lat_lo) bb_lat_lo = lat;
      if (lat > bb_lat_hi) bb_lat_hi = lat;
      if (lon < bb_lon_lo) bb_lon_lo = lon;
      if (lon > bb_lon_hi) bb_lon_hi = lon;
      if (t < bb_t_lo) bb_t_lo = t;
      if (t > bb_t_hi) bb_t_hi = t;
    end
    last_lat = lat;
    last_lon = lon;
    last_t   = t;
    r.total_mm = dist_acc[39:0];
    r.lat_lo = bb_lat_lo[30:0];
    r.lat_hi = bb_lat_hi[30:0];
    r.lon_lo = bb_lon_lo[31:0];
    r.lon_hi = bb_lon_hi[31:0];
    r.t_lo   = bb_t_lo;
    r.t_hi   = bb_t_hi;
    return r;
  endfunction

  task automatic compare_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Requests in, results out; signed fields are compared as raw bits
  always @(posedge clk) begin
    odo_result_t e;
    if (!rst_n) begin
      last_lat <= 0; last_lon <= 0; last_t <= '0; start_t <= '0;
      bb_lat_lo <= 0; bb_lat_hi <= 0; bb_lon_lo <= 0; bb_lon_hi <= 0;
      bb_t_lo <= '0; bb_t_hi <= '0; dist_acc <= 0; seen_point <= 1'b0;
      expected_results.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(predict_point(in_ch.latitude, in_ch.longitude,
                                                 in_ch.time_ms, in_ch.track_start));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          compare_field("total_distance_mm", e.total_mm, out_ch.total_distance_mm);
          compare_field("speed_mm_per_s", e.speed, out_ch.speed_mm_per_s);
          compare_field("speed_valid", e.spd_ok, out_ch.speed_valid);
          compare_field("elapsed_ms", e.elapsed, $unsigned(out_ch.elapsed_ms));
          compare_field("lat_min", e.lat_lo, $unsigned(out_ch.lat_min));
          compare_field("lat_max", e.lat_hi, $unsigned(out_ch.lat_max));
          compare_field("lon_min", e.lon_lo, $unsigned(out_ch.lon_min));
          compare_field("lon_max", e.lon_hi, $unsigned(out_ch.lon_max));
          compare_field("time_min", e.t_lo, out_ch.time_min);
          compare_field("time_max", e.t_hi, out_ch.time_max);
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

/* tb/sv/tb_gps_track_odometer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gps_track_odometer_core
// Drives GPS points into the odometer: a directed set of extremes, interval
// and track-start cases, then random tracks and full-range noise, with random
// gaps and result stalls. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_gps_track_odometer_core;

  localparam int     RANDOM_POINTS = 1250;
  localparam int     QUIET_TAIL    = 150;
  localparam longint CYCLE_LIMIT   = 2000000;
  localparam longint LAT_MAX       = 900000000;
  localparam longint LON_MAX       = 1800000000;
  localparam logic [41:0] T_MAX    = 42'h3FF_FFFF_FFFF;

  logic   clk;
  logic   rst_n;
  logic   gaps_on;
  int     fail_count, outstanding;
  int     stall_left;
  longint cycle_count;

  gto_in_if  in_ch ();
  gto_out_if out_ch ();

  gps_track_odometer_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gto_odometer_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side stalls in bursts
  always @(posedge clk) begin
    if (!rst_n || !gaps_on) begin
      out_ch.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(8);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic longint clamp(longint v, longint lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  // One request; valid stays high unless a gap follows
  task automatic send_point(longint lat, longint lon, logic [41:0] t, logic first_flag);
    if (gaps_on && $urandom_range(4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(9, 1)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.latitude    <= 31'(lat);
    in_ch.longitude   <= 32'(lon);
    in_ch.time_ms     <= t;
    in_ch.track_start <= first_flag;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    longint lat, lon, step_lat, step_lon;
    logic [41:0] t;
    int sent, len, mode;
    bit paused;
    cycle_count       = 0;
    gaps_on           = 1'b1;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.latitude    = '0;
    in_ch.longitude   = '0;
    in_ch.time_ms     = '0;
    in_ch.track_start = 1'b0;
    out_ch.ready      = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first point after reset, extremes, zero and negative intervals
    send_point(0, 0, 1000, 1'b0);
    send_point(LAT_MAX, LON_MAX, 2000, 1'b0);
    send_point(-LAT_MAX, -LON_MAX, 2000, 1'b0);
    send_point(-LAT_MAX, LON_MAX, 1500, 1'b0);
    send_point(899999000, 0, 0, 1'b1);
    send_point(LAT_MAX, 1000000, 10, 1'b0);
    send_point(-800000000, 5, T_MAX, 1'b0);
    send_point(0, 0, 0, 1'b0);
    send_point(0, -LON_MAX, T_MAX, 1'b1);
    send_point(0, LON_MAX, 0, 1'b0);
    send_point(LAT_MAX, LON_MAX, 1, 1'b1);
    send_point(LAT_MAX - 1, LON_MAX, 2, 1'b0);
    // Alternating extremes add long segments to the running total
    for (int i = 0; i < 12; i++)
      send_point((i % 2) ? LAT_MAX : -LAT_MAX, (i % 2) ? -LON_MAX : LON_MAX,
                 42'(100 + i), 1'b0);

    // Random tracks, with some full-range noise
    sent   = 0;
    paused = 0;
    lat = 0; lon = 0; t = 0;
    while (sent < RANDOM_POINTS) begin
      if (sent > RANDOM_POINTS - QUIET_TAIL) gaps_on = 1'b0;
      if (!paused && sent > RANDOM_POINTS / 2) begin
        paused = 1;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      mode = $urandom_range(9);
      if (mode < 7) begin
        // well-formed track: mostly small steps, mostly rising time
        len = $urandom_range(40, 3);
        lat = longint'($urandom_range(1800000000)) - LAT_MAX;
        lon = longint'($urandom_range(32'd3600000000)) - LON_MAX;
        t   = {10'($urandom_range(1023)), $urandom()};
        step_lat = (mode == 6) ? 20000000 : 50000;
        step_lon = (mode == 6) ? 40000000 : 50000;
        for (int k = 0; k < len && sent < RANDOM_POINTS; k++) begin
          send_point(lat, lon, t, k == 0);
          sent++;
          lat = clamp(lat + longint'($urandom_range(2 * step_lat)) - step_lat, LAT_MAX);
          lon = clamp(lon + longint'($urandom_range(2 * step_lon)) - step_lon, LON_MAX);
          case ($urandom_range(19))
            0:       t = t;
            1:       t = t - 42'($urandom_range(5000));
            2:       t = t + 42'($urandom_range(3, 1));
            default: t = t + 42'($urandom_range(10000, 100));
          endcase
        end
      end else begin
        // noise: arbitrary points, arbitrary start flags
        len = $urandom_range(20, 1);
        for (int k = 0; k < len && sent < RANDOM_POINTS; k++) begin
          lat = longint'($urandom_range(1800000000)) - LAT_MAX;
          lon = longint'($urandom_range(32'd3600000000)) - LON_MAX;
          t   = {10'($urandom_range(1023)), $urandom()};
          send_point(lat, lon, t, $urandom_range(7) == 0);
          sent++;
        end
      end
    end
    in_ch.valid <= 1'b0;

    // Drain
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/gto_pkg.sv
rtl/core/gto_if.sv
rtl/core/gps_track_odometer_core.sv
tb/sv/gto_odometer_checker.sv
tb/sv/tb_gps_track_odometer_core.sv
